// File: design/sse_pkg.sv
// ----------------------------------------------------------------------------
// Sorted set engine package
// Command and status codes, cell control types and common widths.
// ----------------------------------------------------------------------------
package sse_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 5;

  // Command codes on in_command.
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  // Status codes on out_status.
  localparam logic [STATUS_W-1:0] ST_ADDED       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP         = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DELETED     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd4;
  localparam logic [STATUS_W-1:0] ST_PRESENT     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NOT_PRESENT = 3'd6;

  // Update broadcast to every cell in the chain.
  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } cell_op_t;

  // Control group from the sequencer to the cells.
  typedef struct packed {
    logic     compare;
    cell_op_t op;
  } cell_ctrl_t;

endpackage

// File: design/sse_cell.sv
// ----------------------------------------------------------------------------
// Sorted set cell
// Holds one entry of the set, compares it against the command value and
// shifts up or down with its neighbors on an insert or a remove.
// ----------------------------------------------------------------------------
module sse_cell import sse_pkg::*; #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic                     clk,
  input  logic [CNT_W-1:0]         count,
  input  logic signed [DATA_W-1:0] value,
  input  cell_ctrl_t               ctrl,
  input  logic                     lt_prev,
  input  logic signed [DATA_W-1:0] prev_data,
  input  logic signed [DATA_W-1:0] next_data,
  output logic signed [DATA_W-1:0] data,
  output logic                     eq,
  output logic                     lt
);

  logic signed [DATA_W-1:0] data_r, data_nxt;
  logic                     eq_r, lt_r;
  logic                     occupied;

  // The entry holds an element when its place is below the fill count.
  assign occupied = ({1'b0, count} > (CNT_W+1)'(IDX));

  // Insert: the first cell not below the value takes it, cells above take
  // their lower neighbor. Remove: cells at or above the hit take the upper one.
  always_comb begin
    data_nxt = data_r;
    case (ctrl.op)
      OP_INSERT: begin
        if (!lt_prev) begin
          data_nxt = prev_data;
        end else if (!lt_r) begin
          data_nxt = value;
        end
      end
      OP_REMOVE: begin
        if (!lt_r) begin
          data_nxt = next_data;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  // Entry storage and registered compare flags.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (ctrl.compare) begin
      eq_r <= occupied && (data_r == value);
      lt_r <= occupied && (data_r < value);
    end
  end

  assign data = data_r;
  assign eq   = eq_r;
  assign lt   = lt_r;

endmodule

// File: design/sorted_set_engine.sv
// out_strobe is registered from the update state, which follows the compare state, and stays high for one cycle.
// Each command passes a compare state in the cell chain and then an update state;
// the next command can be taken in the update state, before its result appears.
// busy is high only during the compare cycle. The receiver cannot stall results.
// Reset (rst_n low, synchronous) empties the set; stored entries are not cleared.
// ----------------------------------------------------------------------------
// Sorted set engine
// Ascending duplicate-free set of signed values kept in a chain of cells,
// with add, delete and query commands.
// ----------------------------------------------------------------------------
module sorted_set_engine import sse_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         in_command,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_strobe,
  output logic [STATUS_W-1:0]      out_status,
  output logic [COUNT_W-1:0]       out_element_count
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CMD_W-1:0]         cmd_r;
  logic signed [DATA_W-1:0] value_r;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     strobe_r;
  logic [STATUS_W-1:0]      status_r, status_nxt;
  logic [COUNT_W-1:0]       elem_cnt_r;
  cell_ctrl_t               ctrl;
  logic                     accept, held, full;

  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]      eq_vec, lt_vec;

  assign busy   = (state_r == S_CMP);
  assign accept = start && !busy;
  assign held   = |eq_vec;
  assign full   = (count_r == CNT_W'(CAPACITY));

  // Sequencer: compare cycle, then update cycle that may take the next command.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  state_nxt = accept ? S_CMP : S_IDLE;
      S_CMP:   state_nxt = S_UPD;
      S_UPD:   state_nxt = accept ? S_CMP : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Decide the update and the status from the registered cell flags.
  always_comb begin
    ctrl.compare = (state_r == S_CMP);
    ctrl.op      = OP_NONE;
    count_nxt    = count_r;
    status_nxt   = held ? ST_PRESENT : ST_NOT_PRESENT;
    if (state_r == S_UPD) begin
      case (cmd_r)
        CMD_ADD: begin
          if (held) begin
            status_nxt = ST_DUP;
          end else if (full) begin
            status_nxt = ST_FULL;
          end else begin
            status_nxt = ST_ADDED;
            ctrl.op    = OP_INSERT;
            count_nxt  = count_r + CNT_W'(1);
          end
        end
        CMD_DELETE: begin
          if (held) begin
            status_nxt = ST_DELETED;
            ctrl.op    = OP_REMOVE;
            count_nxt  = count_r - CNT_W'(1);
          end else begin
            status_nxt = ST_ABSENT;
          end
        end
        default: begin
          status_nxt = held ? ST_PRESENT : ST_NOT_PRESENT;
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      strobe_r <= (state_r == S_UPD);
    end
  end

  // Command capture and result registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_command;
      value_r <= in_value;
    end
    if (state_r == S_UPD) begin
      status_r   <= status_nxt;
      elem_cnt_r <= COUNT_W'(count_nxt);
    end
  end

  // Chain of cells, each linked to its two neighbors.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     lt_prev;
    logic signed [DATA_W-1:0] prev_data, next_data;

    if (i == 0) begin : g_first
      assign lt_prev   = 1'b1;
      assign prev_data = cell_data[i];
    end else begin : g_mid
      assign lt_prev   = lt_vec[i-1];
      assign prev_data = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_data = cell_data[i];
    end else begin : g_next
      assign next_data = cell_data[i+1];
    end

    sse_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .count     (count_r),
      .value     (value_r),
      .ctrl      (ctrl),
      .lt_prev   (lt_prev),
      .prev_data (prev_data),
      .next_data (next_data),
      .data      (cell_data[i]),
      .eq        (eq_vec[i]),
      .lt        (lt_vec[i])
    );
  end

  assign out_strobe        = strobe_r;
  assign out_status        = status_r;
  assign out_element_count = elem_cnt_r;

  // A result follows each update cycle and nothing else.
  a_strobe_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == S_UPD))
    else $error("result strobe without an update cycle");

  // The fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, count_r} <= (CNT_W+1)'(CAPACITY))
    else $error("fill count above capacity");

  // A value held in the set matches in one cell at most.
  a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> $onehot0(eq_vec))
    else $error("value matched in more than one cell");

  // An accepted command always enters the compare cycle next.
  a_accept_to_compare: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_CMP))
    else $error("accepted command did not enter compare");

endmodule

// File: tb/sv/sorted_set_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set checker
// Watches the command and result channels of the sorted set engine, keeps its
// own copy of the set, and compares every result with the predicted one.
// ----------------------------------------------------------------------------
module sorted_set_checker import sse_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic [CMD_W-1:0]         in_command,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     out_strobe,
  input  logic [STATUS_W-1:0]      out_status,
  input  logic [COUNT_W-1:0]       out_element_count,
  output int unsigned              mismatches,
  output int unsigned              pending
);

  // One result: status code and element count after the command.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } set_reply_t;

  set_reply_t               replies_due[$];
  logic signed [DATA_W-1:0] members[CAPACITY];
  int unsigned              member_count = 0;
  int unsigned              error_total = 0;

  // Apply one command to the local copy of the set and return its result.
  function automatic set_reply_t apply_set_command(input logic [CMD_W-1:0] cmd,
                                                   input logic signed [DATA_W-1:0] val);
    set_reply_t  reply;
    int unsigned hit;
    int unsigned pos;
    bit          held;
    hit = member_count;
    for (int unsigned i = 0; i < member_count; i++) begin
      if (members[i] == val && hit == member_count) hit = i;
    end
    held = (hit < member_count);
    case (cmd)
      CMD_ADD: begin
        if (held) begin
          reply.status = ST_DUP;
        end else if (member_count >= CAPACITY) begin
          reply.status = ST_FULL;
        end else begin
          // Find the sorted place, then move larger entries up one slot.
          pos = 0;
          while (pos < member_count && members[pos] < val) pos++;
          for (int unsigned j = member_count; j > pos; j--) members[j] = members[j-1];
          members[pos] = val;
          member_count++;
          reply.status = ST_ADDED;
        end
      end
      CMD_DELETE: begin
        if (held) begin
          for (int unsigned j = hit; j + 1 < member_count; j++) members[j] = members[j+1];
          member_count--;
          reply.status = ST_DELETED;
        end else begin
          reply.status = ST_ABSENT;
        end
      end
      // Query, and the unused code, which acts as a query.
      default: begin
        reply.status = held ? ST_PRESENT : ST_NOT_PRESENT;
      end
    endcase
    reply.count = member_count[COUNT_W-1:0];
    return reply;
  endfunction

  // Predict on every accepted command and check every result transfer.
  always @(posedge clk) begin : watch
    set_reply_t want;
    if (!rst_n) begin
      replies_due.delete();
      member_count = 0;
    end else begin
      if (start && !busy) replies_due.push_back(apply_set_command(in_command, in_value));
      if (out_strobe) begin
        if (replies_due.size() == 0) begin
          $display("%0t: result with none expected: expected none, actual status %0d count %0d",
                   $time, out_status, out_element_count);
          error_total++;
        end else begin
          want = replies_due.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_status);
            error_total++;
          end
          if (out_element_count !== want.count) begin
            $display("%0t: element count mismatch: expected %0d, actual %0d",
                     $time, want.count, out_element_count);
            error_total++;
          end
        end
      end
    end
    pending    <= replies_due.size();
    mismatches <= error_total;
  end

endmodule

// File: tb/sv/sorted_set_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set engine testbench
// Drives directed and random add, delete and query commands with random gaps
// into the engine; a checker beside it predicts and compares every result.
// ----------------------------------------------------------------------------
module sorted_set_engine_tb;
  import sse_pkg::*;

  localparam int unsigned CAPACITY  = 16;
  localparam int unsigned LIMIT     = 300000;
  localparam int unsigned POOL_SIZE = 24;

  // Command code the engine does not define; it must act as a query.
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [CMD_W-1:0]         in_command;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_strobe;
  logic [STATUS_W-1:0]      out_status;
  logic [COUNT_W-1:0]       out_element_count;
  int unsigned              mismatches;
  int unsigned              pending;

  logic signed [DATA_W-1:0] value_pool[POOL_SIZE];
  int unsigned              idle_pct;

  sorted_set_engine #(.CAPACITY(CAPACITY)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_value(in_value),
    .out_strobe(out_strobe), .out_status(out_status),
    .out_element_count(out_element_count)
  );

  sorted_set_checker #(.CAPACITY(CAPACITY)) checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_value(in_value),
    .out_strobe(out_strobe), .out_status(out_status),
    .out_element_count(out_element_count),
    .mismatches(mismatches), .pending(pending)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run guard: a hung handshake ends the run as a failure.
  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("sorted_set_engine_tb failed");
    $finish;
  end

  // Present one command and hold it until the engine takes the transfer.
  task automatic issue(input logic [CMD_W-1:0] cmd, input logic signed [DATA_W-1:0] val);
    in_command <= cmd;
    in_value   <= val;
    start      <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // Random gap after a transfer, taken with the current idle rate.
  task automatic maybe_idle();
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Hold off until every result already owed has come back.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Fresh pool of candidate values; extremes always stay in it.
  task automatic refresh_pool();
    value_pool[0] = VAL_MIN;
    value_pool[1] = VAL_MAX;
    value_pool[2] = '0;
    value_pool[3] = -1;
    for (int i = 4; i < POOL_SIZE; i++) begin
      if ($urandom_range(0, 1) == 0) value_pool[i] = $signed($urandom_range(0, 64)) - 32;
      else value_pool[i] = $urandom;
    end
  endtask

  initial begin
    int unsigned              add_pct;
    int unsigned              pick;
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] val;

    rst_n      = 1'b0;
    start      = 1'b0;
    in_command = CMD_QUERY;
    in_value   = '0;
    idle_pct   = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty set, extremes, duplicates, the unused code, a full store.
    issue(CMD_QUERY, 32'sd5);
    issue(CMD_DELETE, 32'sd5);
    issue(CMD_ADD, VAL_MIN);
    issue(CMD_ADD, VAL_MAX);
    issue(CMD_ADD, 32'sd0);
    issue(CMD_ADD, -32'sd1);
    issue(CMD_ADD, 32'sd0);
    issue(CMD_SPARE, VAL_MAX);
    issue(CMD_SPARE, 32'sd7);
    issue(CMD_DELETE, -32'sd1);
    for (int i = 0; i < 13; i++) issue(CMD_ADD, i * 1000003 - 6000000);
    issue(CMD_ADD, 32'sd12345);
    issue(CMD_ADD, 32'sd0);
    issue(CMD_DELETE, VAL_MIN);
    drain();

    // Random: blocks with their own mix of adds and deletes, so the set
    // swings between empty and full. The last blocks run without gaps.
    for (int blk = 0; blk < 13; blk++) begin
      refresh_pool();
      add_pct = $urandom_range(15, 85);
      if (blk >= 11 || $urandom_range(0, 2) == 0) idle_pct = 0;
      else idle_pct = $urandom_range(10, 60);
      for (int i = 0; i < 100; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < add_pct) cmd = CMD_ADD;
        else if (pick < add_pct + (100 - add_pct) / 2) cmd = CMD_DELETE;
        else if (pick < 97) cmd = CMD_QUERY;
        else cmd = CMD_SPARE;
        if ($urandom_range(0, 99) < 85) val = value_pool[$urandom_range(0, POOL_SIZE - 1)];
        else val = $urandom;
        issue(cmd, val);
        maybe_idle();
      end
      if (blk == 5 || blk == 9) drain();
    end

    // Wait for the last results, then allow the pipeline to settle.
    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("sorted_set_engine_tb passed");
    end else begin
      $display("sorted_set_engine_tb failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/sse_pkg.sv
design/sse_cell.sv
design/sorted_set_engine.sv
tb/sv/sorted_set_checker.sv
tb/sv/sorted_set_engine_tb.sv
